FILE: sv/qs_pkg.sv
package qs_pkg;

	localparam int FRAC_BITS = 14;
	localparam int DW = 16;
	localparam int TW = 15;
	localparam logic [TW-1:0] ONE = TW'(1 << FRAC_BITS);
	localparam logic [TW-1:0] THR_RESET = TW'(16);

	// dot product and square root
	localparam int PROD_W = 2 * DW;
	localparam int DOT_W = PROD_W + 2;
	localparam int MAG_W = FRAC_BITS;
	localparam int SQ_W = FRAC_BITS + 1;
	localparam int SQ_REM_W = 2 * FRAC_BITS + 2;

	// cordic, angles in Q32 radians, vectors in Q30
	localparam int Q30 = 30;
	localparam int CW = 36;
	localparam int ANG_W = 34;
	localparam logic [ANG_W-1:0] ANG_PI = 34'd13493037705;
	localparam logic [ANG_W-1:0] ANG_HALF_PI = 34'd6746518852;
	localparam int AM_W = ANG_W + TW;

	// divisions and final weighting
	localparam int GAIN_W = 31;
	localparam int SIN_W = 32;
	localparam int RATIO_Q_W = SIN_W + FRAC_BITS;
	localparam int RATIO_W = 45;
	localparam logic [RATIO_Q_W-1:0] RATIO_MAX = RATIO_Q_W'(1) << (RATIO_W - 1);
	localparam int RL_W = 23;
	localparam int RH_W = RATIO_W - RL_W;
	localparam int SUM_W = 64;

	localparam logic [31:0] ATAN_Q32 [11] = '{
		32'd3373259426, 32'd1991351318, 32'd1052175346, 32'd534100635,
		32'd268086748, 32'd134174063, 32'd67103403, 32'd33553749,
		32'd16777131, 32'd8388597, 32'd4194303
	};

	typedef logic signed [DW-1:0] comp_t;

	typedef enum logic [1:0] {
		PATH_SLERP = 2'd0,
		PATH_START = 2'd1,
		PATH_MID   = 2'd2,
		PATH_SAT   = 2'd3
	} path_t;

	typedef struct packed {
		logic signed [DW-1:0] start_x;
		logic signed [DW-1:0] start_y;
		logic signed [DW-1:0] start_z;
		logic signed [DW-1:0] start_w;
		logic signed [DW-1:0] end_x;
		logic signed [DW-1:0] end_y;
		logic signed [DW-1:0] end_z;
		logic signed [DW-1:0] end_w;
		logic [TW-1:0]        blend;
	} req_t;

	typedef struct packed {
		logic signed [DW-1:0] out_x;
		logic signed [DW-1:0] out_y;
		logic signed [DW-1:0] out_z;
		logic signed [DW-1:0] out_w;
		path_t                path_taken;
	} res_t;

	// what travels with a request down the pipeline
	typedef struct packed {
		comp_t [3:0]     a;
		comp_t [3:0]     e;
		logic [TW-1:0]   t;
		logic            early;
		logic            cneg;
		logic            mid;
		logic [SQ_W-1:0] s;
	} side_t;

	function automatic logic [31:0] step_angle(input int i);
		logic [63:0] p;
		p = 64'd1 << (32 - i);
		if (i < 11) begin
			return ATAN_Q32[4'(i)];
		end
		return p[31:0];
	endfunction

	function automatic logic [GAIN_W-1:0] cordic_gain(input int steps);
		logic [63:0] p;
		logic [63:0] v;
		logic [63:0] r;
		logic [63:0] b;
		p = 64'd1 << 60;
		for (int i = 0; i < 32; i++) begin
			if (i < steps) begin
				p = p + (p >> (2 * i));
			end
		end
		v = p;
		r = '0;
		for (int j = 31; j >= 0; j--) begin
			b = 64'd1 << (2 * j);
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
		end
		return r[GAIN_W-1:0];
	endfunction

endpackage

FILE: sv/qs_div.sv
module qs_div
	import qs_pkg::*;
#(
	parameter int DEN_W = 16,
	parameter int Q_W = 16
) (
	input  logic                   clk,
	input  logic [DEN_W+Q_W-1:0]   num,
	input  logic [DEN_W-1:0]       den,
	output logic [Q_W-1:0]         quo
);

	localparam int AW = DEN_W + Q_W;

	// remainder in the upper bits, numerator bits shift out, quotient bits shift in
	logic [AW-1:0]    acc_s [1:Q_W];
	logic [DEN_W-1:0] den_s [1:Q_W-1];

	for (genvar k = 0; k < Q_W; k++) begin : g_step
		logic [AW-1:0]    acc_in;
		logic [DEN_W-1:0] den_in;
		logic [DEN_W:0]   top;
		logic [DEN_W:0]   diff;
		logic             ge;

		if (k == 0) begin : g_first
			assign acc_in = num;
			assign den_in = den;
		end else begin : g_next
			assign acc_in = acc_s[k];
			assign den_in = den_s[k];
		end

		always_comb begin
			top = acc_in[AW-1:Q_W-1];
			ge = top >= {1'b0, den_in};
			diff = top - {1'b0, den_in};
		end

		always_ff @(posedge clk) begin
			acc_s[k+1] <= {ge ? diff[DEN_W-1:0] : top[DEN_W-1:0], acc_in[Q_W-2:0], ge};
		end

		if (k < Q_W - 1) begin : g_den
			always_ff @(posedge clk) begin
				den_s[k+1] <= den_in;
			end
		end
	end

	assign quo = acc_s[Q_W][Q_W-1:0];

endmodule

FILE: sv/qs_delay.sv
module qs_delay
	import qs_pkg::*;
#(
	parameter int W = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic [W-1:0] in_data,
	output logic         out_valid,
	output logic [W-1:0] out_data
);

	logic         v_s [1:DEPTH];
	logic [W-1:0] d_s [1:DEPTH];

	for (genvar k = 0; k < DEPTH; k++) begin : g_tap
		logic         v_in;
		logic [W-1:0] d_in;

		if (k == 0) begin : g_first
			assign v_in = in_valid;
			assign d_in = in_data;
		end else begin : g_next
			assign v_in = v_s[k];
			assign d_in = d_s[k];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k+1] <= 1'b0;
			end else begin
				v_s[k+1] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			d_s[k+1] <= d_in;
		end
	end

	assign out_valid = v_s[DEPTH];
	assign out_data = d_s[DEPTH];

endmodule

FILE: sv/quaternion_slerp.sv
// throughput: one request per cycle, busy stays low; the depth is set by the square root,
// the two cordic chains, three stages that remove the cordic gain by a reciprocal multiply
// and the bit-per-stage divider for sine over s
// reset clears every valid bit and loads the threshold thr_q with 16; results are not
// held back, done pulses for one cycle with the result
module quaternion_slerp
	import qs_pkg::*;
#(
	parameter int CORDIC_STEPS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  req_t          req,
	output logic          done,
	output res_t          result,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [TW-1:0] cfg_data
);

	localparam int N = CORDIC_STEPS;
	localparam logic [GAIN_W-1:0] GAIN = cordic_gain(CORDIC_STEPS);
	localparam logic [SIN_W-1:0] RECIP = SIN_W'((64'd1 << (Q30 + SIN_W)) / 64'(GAIN));
	localparam int DIV1_Q = 3;
	localparam int DIV2_Q = RATIO_Q_W;
	localparam int LATENCY = 4 + SQ_W + 1 + N + 3 + N + DIV1_Q + DIV2_Q + 4;

	logic [TW-1:0] thr_q;
	logic          accept;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= cfg_data;
		end
	end

	// stage 1: capture, clamp blend
	side_t side_in;
	logic  v_s1;
	side_t side_s1;

	always_comb begin
		side_in = '0;
		side_in.a[0] = req.start_x;
		side_in.a[1] = req.start_y;
		side_in.a[2] = req.start_z;
		side_in.a[3] = req.start_w;
		side_in.e[0] = req.end_x;
		side_in.e[1] = req.end_y;
		side_in.e[2] = req.end_z;
		side_in.e[3] = req.end_w;
		side_in.t = (req.blend > ONE) ? ONE : req.blend;
	end

	// stage 2: products
	logic                       v_s2;
	side_t                      side_s2;
	logic signed [PROD_W-1:0]   prod_s2 [4];

	// stage 3: dot product, magnitude
	logic                       v_s3;
	side_t                      side_s3;
	logic [MAG_W-1:0]           mag_s3;
	logic signed [DOT_W-1:0]    dot;
	logic [DOT_W-1:0]           abs_dot;
	logic [MAG_W-1:0]           mag_n;
	side_t                      side_n3;

	always_comb begin
		dot = DOT_W'(prod_s2[0]) + DOT_W'(prod_s2[1]) + DOT_W'(prod_s2[2]) + DOT_W'(prod_s2[3]);
		abs_dot = dot[DOT_W-1] ? DOT_W'(-dot) : DOT_W'(dot);
		mag_n = abs_dot[FRAC_BITS+MAG_W-1:FRAC_BITS];
		side_n3 = side_s2;
		side_n3.early = abs_dot >= (DOT_W'(1) << (2 * FRAC_BITS));
		// a dot that truncates to zero is not negative
		side_n3.cneg = dot[DOT_W-1] && (mag_n != '0);
	end

	// square root chain, entry 0 is stage 4
	logic                  sq_v_s    [0:SQ_W];
	side_t                 sq_side_s [0:SQ_W];
	logic [SQ_REM_W-1:0]   sq_rem_s  [0:SQ_W];
	logic [SQ_W-1:0]       sq_root_s [0:SQ_W];
	logic [MAG_W-1:0]      sq_mag_s  [0:SQ_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			sq_v_s[0] <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			sq_v_s[0] <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		side_s1 <= side_in;
		side_s2 <= side_s1;
		for (int k = 0; k < 4; k++) begin
			prod_s2[k] <= $signed(side_s1.a[k]) * $signed(side_s1.e[k]);
		end
		side_s3 <= side_n3;
		mag_s3 <= mag_n;
		sq_side_s[0] <= side_s3;
		sq_mag_s[0] <= mag_s3;
		sq_root_s[0] <= '0;
		sq_rem_s[0] <= (SQ_REM_W'(1) << (2 * FRAC_BITS)) - SQ_REM_W'(mag_s3) * SQ_REM_W'(mag_s3);
	end

	for (genvar k = 0; k < SQ_W; k++) begin : g_sqrt
		localparam int B = SQ_W - 1 - k;
		logic [31:0] trial;
		logic        take;

		always_comb begin
			trial = (32'(sq_root_s[k]) << (B + 1)) + (32'd1 << (2 * B));
			take = 32'(sq_rem_s[k]) >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[k+1] <= 1'b0;
			end else begin
				sq_v_s[k+1] <= sq_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			sq_rem_s[k+1] <= take ? SQ_REM_W'(32'(sq_rem_s[k]) - trial) : sq_rem_s[k];
			sq_root_s[k+1] <= take ? (sq_root_s[k] | (SQ_W'(1) << B)) : sq_root_s[k];
			sq_mag_s[k+1] <= sq_mag_s[k];
			sq_side_s[k+1] <= sq_side_s[k];
		end
	end

	// vectoring cordic for acos, entry 0 loads (mag, s) in Q30
	logic                 vc_v_s    [0:N];
	side_t                vc_side_s [0:N];
	logic signed [CW-1:0] vc_x_s    [0:N];
	logic signed [CW-1:0] vc_y_s    [0:N];
	logic signed [CW-1:0] vc_z_s    [0:N];
	side_t                vside;

	always_comb begin
		vside = sq_side_s[SQ_W];
		vside.s = sq_root_s[SQ_W];
		vside.mid = sq_root_s[SQ_W] < thr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_v_s[0] <= 1'b0;
		end else begin
			vc_v_s[0] <= sq_v_s[SQ_W];
		end
	end

	always_ff @(posedge clk) begin
		vc_side_s[0] <= vside;
		vc_x_s[0] <= $signed(CW'(sq_mag_s[SQ_W]) << (Q30 - FRAC_BITS));
		vc_y_s[0] <= $signed(CW'(sq_root_s[SQ_W]) << (Q30 - FRAC_BITS));
		vc_z_s[0] <= '0;
	end

	for (genvar i = 0; i < N; i++) begin : g_vec
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;
		logic signed [CW-1:0] ang;

		assign dx = vc_y_s[i] >>> i;
		assign dy = vc_x_s[i] >>> i;
		assign ang = $signed(CW'(step_angle(i)));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vc_v_s[i+1] <= 1'b0;
			end else begin
				vc_v_s[i+1] <= vc_v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			vc_side_s[i+1] <= vc_side_s[i];
			if (!vc_y_s[i][CW-1]) begin
				vc_x_s[i+1] <= vc_x_s[i] + dx;
				vc_y_s[i+1] <= vc_y_s[i] - dy;
				vc_z_s[i+1] <= vc_z_s[i] + ang;
			end else begin
				vc_x_s[i+1] <= vc_x_s[i] - dx;
				vc_y_s[i+1] <= vc_y_s[i] + dy;
				vc_z_s[i+1] <= vc_z_s[i] - ang;
			end
		end
	end

	// theta: clamp to [0, pi/2], mirror for a negative cosine
	logic                 th_v_s;
	side_t                th_side_s;
	logic [ANG_W-1:0]     th_s;
	logic [ANG_W-1:0]     th_clamp;
	logic signed [CW-1:0] zf;

	always_comb begin
		zf = vc_z_s[N];
		if (zf[CW-1]) begin
			th_clamp = '0;
		end else if (zf > $signed(CW'(ANG_HALF_PI))) begin
			th_clamp = ANG_HALF_PI;
		end else begin
			th_clamp = zf[ANG_W-1:0];
		end
	end

	// blend the angle, two lanes: (1 - t) theta and t theta
	logic             am_v_s;
	side_t            am_side_s;
	logic [ANG_W-1:0] am_ang_s [2];
	logic [AM_W-1:0]  am_prod  [2];

	always_comb begin
		am_prod[0] = AM_W'(ONE - th_side_s.t) * AM_W'(th_s);
		am_prod[1] = AM_W'(th_side_s.t) * AM_W'(th_s);
	end

	// rotation cordic lanes for the two sines, entry 0 folds the angle into [0, pi/2]
	logic                 rt_v_s    [0:N];
	side_t                rt_side_s [0:N];
	logic signed [CW-1:0] rt_x_s    [2][0:N];
	logic signed [CW-1:0] rt_y_s    [2][0:N];
	logic signed [CW-1:0] rt_z_s    [2][0:N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			th_v_s <= 1'b0;
			am_v_s <= 1'b0;
			rt_v_s[0] <= 1'b0;
		end else begin
			th_v_s <= vc_v_s[N];
			am_v_s <= th_v_s;
			rt_v_s[0] <= am_v_s;
		end
	end

	always_ff @(posedge clk) begin
		th_side_s <= vc_side_s[N];
		th_s <= vc_side_s[N].cneg ? ANG_PI - th_clamp : th_clamp;
		am_side_s <= th_side_s;
		for (int l = 0; l < 2; l++) begin
			am_ang_s[l] <= am_prod[l][ANG_W+FRAC_BITS-1:FRAC_BITS];
		end
		rt_side_s[0] <= am_side_s;
	end

	for (genvar l = 0; l < 2; l++) begin : g_lane
		always_ff @(posedge clk) begin
			rt_x_s[l][0] <= $signed(CW'(1) << Q30);
			rt_y_s[l][0] <= '0;
			if (am_ang_s[l] > ANG_HALF_PI) begin
				rt_z_s[l][0] <= $signed(CW'(ANG_PI - am_ang_s[l]));
			end else begin
				rt_z_s[l][0] <= $signed(CW'(am_ang_s[l]));
			end
		end

		for (genvar i = 0; i < N; i++) begin : g_rot
			logic signed [CW-1:0] dx;
			logic signed [CW-1:0] dy;
			logic signed [CW-1:0] ang;

			assign dx = rt_y_s[l][i] >>> i;
			assign dy = rt_x_s[l][i] >>> i;
			assign ang = $signed(CW'(step_angle(i)));

			always_ff @(posedge clk) begin
				if (!rt_z_s[l][i][CW-1]) begin
					rt_x_s[l][i+1] <= rt_x_s[l][i] - dx;
					rt_y_s[l][i+1] <= rt_y_s[l][i] + dy;
					rt_z_s[l][i+1] <= rt_z_s[l][i] - ang;
				end else begin
					rt_x_s[l][i+1] <= rt_x_s[l][i] + dx;
					rt_y_s[l][i+1] <= rt_y_s[l][i] - dy;
					rt_z_s[l][i+1] <= rt_z_s[l][i] + ang;
				end
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_rot_ctl
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_v_s[i+1] <= 1'b0;
			end else begin
				rt_v_s[i+1] <= rt_v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			rt_side_s[i+1] <= rt_side_s[i];
		end
	end

	// remove the cordic gain, then divide each sine by s
	logic                   d1_v;
	side_t                  d1_side;
	logic                   d2_v;
	side_t                  d2_side;
	logic [SIN_W-1:0]       sin30 [2];
	logic [RATIO_Q_W-1:0]   quo2  [2];

	qs_delay #(
		.W($bits(side_t)),
		.DEPTH(DIV1_Q)
	) u_dly_sin (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(rt_v_s[N]),
		.in_data(rt_side_s[N]),
		.out_valid(d1_v),
		.out_data(d1_side)
	);

	qs_delay #(
		.W($bits(side_t)),
		.DEPTH(DIV2_Q)
	) u_dly_ratio (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(d1_v),
		.in_data(d1_side),
		.out_valid(d2_v),
		.out_data(d2_side)
	);

	for (genvar l = 0; l < 2; l++) begin : g_div
		logic [GAIN_W-1:0]         y_pos;
		logic [GAIN_W+SIN_W-1:0]   est;
		logic [GAIN_W+SIN_W-1:0]   rem;
		logic [GAIN_W-1:0]         gy_s1;
		logic [SIN_W-1:0]          gq_s1;
		logic [GAIN_W-1:0]         gy_s2;
		logic [SIN_W-1:0]          gq_s2;
		logic [GAIN_W+SIN_W-1:0]   gp_s2;
		logic [SQ_W+RATIO_Q_W-1:0] num2;

		assign y_pos = rt_y_s[l][N][CW-1] ? '0 : rt_y_s[l][N][GAIN_W-1:0];
		// reciprocal estimate of y * 2^30 / gain, exact or one short
		assign est = (GAIN_W + SIN_W)'(y_pos) * (GAIN_W + SIN_W)'(RECIP);
		assign rem = ((GAIN_W + SIN_W)'(gy_s2) << Q30) - gp_s2;
		assign num2 = (SQ_W + RATIO_Q_W)'(sin30[l]) << FRAC_BITS;

		always_ff @(posedge clk) begin
			gy_s1 <= y_pos;
			gq_s1 <= SIN_W'(est >> SIN_W);
			gy_s2 <= gy_s1;
			gq_s2 <= gq_s1;
			gp_s2 <= (GAIN_W + SIN_W)'(gq_s1) * (GAIN_W + SIN_W)'(GAIN);
			sin30[l] <= (rem >= (GAIN_W + SIN_W)'(GAIN)) ? gq_s2 + SIN_W'(1) : gq_s2;
		end

		qs_div #(
			.DEN_W(SQ_W),
			.Q_W(RATIO_Q_W)
		) u_div_ratio (
			.clk(clk),
			.num(num2),
			.den(d1_side.s),
			.quo(quo2[l])
		);
	end

	// ratio clamp, partial products, sum, output
	logic                       rc_v_s;
	side_t                      rc_side_s;
	logic [RATIO_W-1:0]         rc_ratio_s [2];
	logic                       m1_v_s;
	side_t                      m1_side_s;
	logic signed [DW+RL_W:0]    m1_lo_s [2][4];
	logic signed [DW+RH_W:0]    m1_hi_s [2][4];
	logic                       m2_v_s;
	side_t                      m2_side_s;
	logic signed [SUM_W-1:0]    m2_sum_s [4];
	logic                       done_q;
	res_t                       result_q;

	res_t                    res_n;
	comp_t                   full [4];
	comp_t                   midv [4];
	comp_t                   pick [4];
	logic                    sat;
	logic signed [SUM_W-1:0] v;
	logic signed [DW:0]      pair;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rc_v_s <= 1'b0;
			m1_v_s <= 1'b0;
			m2_v_s <= 1'b0;
			done_q <= 1'b0;
		end else begin
			rc_v_s <= d2_v;
			m1_v_s <= rc_v_s;
			m2_v_s <= m1_v_s;
			done_q <= m2_v_s;
		end
	end

	always_ff @(posedge clk) begin
		rc_side_s <= d2_side;
		for (int l = 0; l < 2; l++) begin
			rc_ratio_s[l] <= (quo2[l] > RATIO_MAX) ? RATIO_MAX[RATIO_W-1:0] : quo2[l][RATIO_W-1:0];
		end
		m1_side_s <= rc_side_s;
		for (int k = 0; k < 4; k++) begin
			m1_lo_s[0][k] <= $signed(rc_side_s.a[k]) * $signed({1'b0, rc_ratio_s[0][RL_W-1:0]});
			m1_hi_s[0][k] <= $signed(rc_side_s.a[k]) *
				$signed({1'b0, rc_ratio_s[0][RATIO_W-1:RL_W]});
			m1_lo_s[1][k] <= $signed(rc_side_s.e[k]) * $signed({1'b0, rc_ratio_s[1][RL_W-1:0]});
			m1_hi_s[1][k] <= $signed(rc_side_s.e[k]) *
				$signed({1'b0, rc_ratio_s[1][RATIO_W-1:RL_W]});
		end
		m2_side_s <= m1_side_s;
		for (int k = 0; k < 4; k++) begin
			// round half up before the Q30 shift
			m2_sum_s[k] <= (SUM_W'(m1_hi_s[0][k]) <<< RL_W) + SUM_W'(m1_lo_s[0][k]) +
				(SUM_W'(m1_hi_s[1][k]) <<< RL_W) + SUM_W'(m1_lo_s[1][k]) +
				(SUM_W'(64'sd1) <<< (Q30 - 1));
		end
		result_q <= res_n;
	end

	always_comb begin
		sat = 1'b0;
		for (int k = 0; k < 4; k++) begin
			v = m2_sum_s[k] >>> Q30;
			if (v > SUM_W'(64'sd32767)) begin
				full[k] = 16'sh7FFF;
				sat = 1'b1;
			end else if (v < -SUM_W'(64'sd32768)) begin
				full[k] = 16'sh8000;
				sat = 1'b1;
			end else begin
				full[k] = v[DW-1:0];
			end
			pair = (DW+1)'($signed(m2_side_s.a[k])) + (DW+1)'($signed(m2_side_s.e[k]));
			midv[k] = pair[DW:1];
		end
		if (m2_side_s.early) begin
			pick = '{m2_side_s.a[0], m2_side_s.a[1], m2_side_s.a[2], m2_side_s.a[3]};
			res_n.path_taken = PATH_START;
		end else if (m2_side_s.mid) begin
			pick = midv;
			res_n.path_taken = PATH_MID;
		end else begin
			pick = full;
			res_n.path_taken = sat ? PATH_SAT : PATH_SLERP;
		end
		res_n.out_x = pick[0];
		res_n.out_y = pick[1];
		res_n.out_z = pick[2];
		res_n.out_w = pick[3];
	end

	assign done = done_q;
	assign result = result_q;

endmodule

FILE: sv/qs_check.sv
module qs_check
	import qs_pkg::*;
#(
	parameter int LAT = 137
) (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input req_t          req,
	input logic          done,
	input res_t          result,
	input logic          cfg_valid,
	input logic          cfg_ready,
	input logic [TW-1:0] cfg_data
);

	function automatic logic [DW-1:0] mid16(input logic [DW-1:0] p, input logic [DW-1:0] q);
		logic [DW:0] s;
		s = {p[DW-1], p} + {q[DW-1], q};
		return s[DW:1];
	endfunction

	a_req_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("request did not complete on time");

	a_done_req: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without a request");

	a_start_path: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.path_taken == PATH_START) |->
		(result.out_x == $past(req.start_x, LAT) && result.out_y == $past(req.start_y, LAT) &&
		result.out_z == $past(req.start_z, LAT) && result.out_w == $past(req.start_w, LAT)))
		else $error("start path does not return the start quaternion");

	a_mid_path: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.path_taken == PATH_MID) |->
		(result.out_x == mid16($past(req.start_x, LAT), $past(req.end_x, LAT)) &&
		result.out_w == mid16($past(req.start_w, LAT), $past(req.end_w, LAT))))
		else $error("midpoint path mismatch");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && !cfg_ready) |=> $stable(cfg_data))
		else $error("config data changed while stalled");

endmodule

bind quaternion_slerp qs_check #(.LAT(LATENCY)) u_qs_check (.*);
